// ----- src/tpt_pkg.sv -----
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared defaults and latency figure for the trapezoid profile timing block.
// ----------------------------------------------------------------------------
package tpt_pkg;

  localparam int unsigned WordWidthDef = 32;
  localparam int unsigned FracBitsDef  = 16;

  // start-to-strobe latency: front end, root, root alignment, dividers, back end
  function automatic int unsigned tpt_latency(int unsigned w, int unsigned f);
    return 3 * w - f + 8;
  endfunction

endpackage

// ----- src/tpt_front.sv -----
// ----------------------------------------------------------------------------
// tpt_front
// Magnitudes, squares and the triangular test: four register stages.
// ----------------------------------------------------------------------------
module tpt_front import tpt_pkg::*; #(
  parameter int unsigned WORD_WIDTH = WordWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [WORD_WIDTH-1:0]   distance_i,
  input  logic [WORD_WIDTH-1:0]   start_speed_i,
  input  logic [WORD_WIDTH-1:0]   end_speed_i,
  input  logic [WORD_WIDTH-2:0]   speed_limit_i,
  input  logic [WORD_WIDTH-2:0]   accel_limit_i,
  output logic                    valid_o,
  output logic [2*WORD_WIDTH:0]   sum_o,
  output logic [2*WORD_WIDTH:0]   excess_o,
  output logic                    tri_o,
  output logic [WORD_WIDTH-1:0]   start_mag_o,
  output logic [WORD_WIDTH-1:0]   end_mag_o,
  output logic [WORD_WIDTH-2:0]   limit_o,
  output logic [WORD_WIDTH-2:0]   accel_o
);

  localparam int unsigned W  = WORD_WIDTH;
  localparam int unsigned AW = WORD_WIDTH - 1;

  // stage a: magnitudes
  logic          valid_a_q;
  logic [W-1:0]  dist_a_q, v0_a_q, vt_a_q;
  logic [AW-1:0] vm_a_q, am_a_q;
  logic [W-1:0]  dist_mag, v0_mag, vt_mag;
  logic [AW-1:0] am_nz;

  // stage b: products
  logic            valid_b_q;
  logic [2*W-1:0]  v0sq_b_q, vtsq_b_q;
  logic [2*W-2:0]  ad_b_q;
  logic [2*W-3:0]  vmsq_b_q;
  logic [W-1:0]    v0_b_q, vt_b_q;
  logic [AW-1:0]   vm_b_q, am_b_q;

  // stage c: sums
  logic            valid_c_q;
  logic [2*W:0]    sum_c_q;
  logic [2*W-2:0]  lim2_c_q;
  logic [W-1:0]    v0_c_q, vt_c_q;
  logic [AW-1:0]   vm_c_q, am_c_q;

  // stage d: compare and excess
  logic            valid_d_q;
  logic [2*W:0]    sum_d_q, excess_d_q;
  logic            tri_d_q;
  logic [W-1:0]    v0_d_q, vt_d_q;
  logic [AW-1:0]   vm_d_q, am_d_q;
  logic [2*W:0]    lim2_ext;
  logic            tri_d;

  assign dist_mag = distance_i[W-1]    ? (~distance_i + 1'b1)    : distance_i;
  assign v0_mag   = start_speed_i[W-1] ? (~start_speed_i + 1'b1) : start_speed_i;
  assign vt_mag   = end_speed_i[W-1]   ? (~end_speed_i + 1'b1)   : end_speed_i;
  // zero acceleration limit counts as one lsb
  assign am_nz    = (accel_limit_i == '0) ? AW'(1) : accel_limit_i;

  assign lim2_ext = {2'b00, lim2_c_q};
  assign tri_d    = lim2_ext >= sum_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
      valid_d_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
      valid_d_q <= valid_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_a_q <= dist_mag;
    v0_a_q   <= v0_mag;
    vt_a_q   <= vt_mag;
    vm_a_q   <= speed_limit_i;
    am_a_q   <= am_nz;

    v0sq_b_q <= v0_a_q * v0_a_q;
    vtsq_b_q <= vt_a_q * vt_a_q;
    ad_b_q   <= am_a_q * dist_a_q;
    vmsq_b_q <= vm_a_q * vm_a_q;
    v0_b_q   <= v0_a_q;
    vt_b_q   <= vt_a_q;
    vm_b_q   <= vm_a_q;
    am_b_q   <= am_a_q;

    sum_c_q  <= {1'b0, v0sq_b_q} + {1'b0, vtsq_b_q} + {1'b0, ad_b_q, 1'b0};
    lim2_c_q <= {vmsq_b_q, 1'b0};
    v0_c_q   <= v0_b_q;
    vt_c_q   <= vt_b_q;
    vm_c_q   <= vm_b_q;
    am_c_q   <= am_b_q;

    sum_d_q    <= sum_c_q;
    tri_d_q    <= tri_d;
    excess_d_q <= tri_d ? '0 : (sum_c_q - lim2_ext);
    v0_d_q     <= v0_c_q;
    vt_d_q     <= vt_c_q;
    vm_d_q     <= vm_c_q;
    am_d_q     <= am_c_q;
  end

  assign valid_o     = valid_d_q;
  assign sum_o       = sum_d_q;
  assign excess_o    = excess_d_q;
  assign tri_o       = tri_d_q;
  assign start_mag_o = v0_d_q;
  assign end_mag_o   = vt_d_q;
  assign limit_o     = vm_d_q;
  assign accel_o     = am_d_q;

endmodule

// ----- src/tpt_sqrt.sv -----
// ----------------------------------------------------------------------------
// tpt_sqrt
// Pipelined floored square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tpt_sqrt import tpt_pkg::*; #(
  parameter int unsigned WORD_WIDTH = WordWidthDef,
  parameter int unsigned SIDE_W     = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [2*WORD_WIDTH-1:0] rad_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    valid_o,
  output logic [WORD_WIDTH-1:0]   root_o,
  output logic [SIDE_W-1:0]       side_o
);

  localparam int unsigned W  = WORD_WIDTH;
  localparam int unsigned RW = 2 * WORD_WIDTH + 1;

  // residue is radicand minus root squared
  logic [RW-1:0]     rem_q   [W+1];
  logic [W-1:0]      root_q  [W+1];
  logic [SIDE_W-1:0] side_q  [W+1];
  logic              valid_q [W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= RW'(rad_i);
    root_q[0] <= '0;
    side_q[0] <= side_i;
  end

  for (genvar s = 0; s < W; s++) begin : g_step
    localparam int unsigned B = W - 1 - s;
    logic [RW-1:0] trial;
    logic          ge;
    logic [W-1:0]  root_nx;

    always_comb begin
      trial      = (RW'(root_q[s]) << (B + 1)) | (RW'(1) << (2 * B));
      ge         = rem_q[s] >= trial;
      root_nx    = root_q[s];
      root_nx[B] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else begin
        valid_q[s+1] <= valid_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= ge ? (rem_q[s] - trial) : rem_q[s];
      root_q[s+1] <= root_nx;
      side_q[s+1] <= side_q[s];
    end
  end

  assign valid_o = valid_q[W];
  assign root_o  = root_q[W];
  assign side_o  = side_q[W];

endmodule

// ----- src/tpt_div.sv -----
// ----------------------------------------------------------------------------
// tpt_div
// Pipelined restoring divider, one quotient bit per stage, with an up-front
// overflow check against the quotient width.
// ----------------------------------------------------------------------------
module tpt_div import tpt_pkg::*; #(
  parameter int unsigned NUM_W  = 2 * WordWidthDef,
  parameter int unsigned DEN_W  = WordWidthDef,
  parameter int unsigned Q_W    = WordWidthDef,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quo_o,
  output logic              ovf_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned HI_W  = NUM_W - Q_W;
  localparam int unsigned CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [DEN_W-1:0]  rem_q   [Q_W+1];
  logic [Q_W-1:0]    low_q   [Q_W+1];
  logic [Q_W-1:0]    quo_q   [Q_W+1];
  logic [DEN_W-1:0]  den_q   [Q_W+1];
  logic              ovf_q   [Q_W+1];
  logic [SIDE_W-1:0] side_q  [Q_W+1];
  logic              valid_q [Q_W+1];

  logic [HI_W+DEN_W-1:0] hi_ext;
  logic                  ovf_in;

  // quotient does not fit when num >= den * 2^Q_W
  assign hi_ext = {{DEN_W{1'b0}}, num_i[NUM_W-1:Q_W]};
  assign ovf_in = CMP_W'(num_i) >= (CMP_W'(den_i) << Q_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= hi_ext[DEN_W-1:0];
    low_q[0]  <= num_i[Q_W-1:0];
    quo_q[0]  <= '0;
    den_q[0]  <= den_i;
    ovf_q[0]  <= ovf_in;
    side_q[0] <= side_i;
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_step
    localparam int unsigned I = Q_W - 1 - s;
    logic [DEN_W:0]   part;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [Q_W-1:0]   quo_nx;

    always_comb begin
      part      = {rem_q[s], low_q[s][I]};
      diff      = part - {1'b0, den_q[s]};
      ge        = part >= {1'b0, den_q[s]};
      quo_nx    = quo_q[s];
      quo_nx[I] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else begin
        valid_q[s+1] <= valid_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
      low_q[s+1]  <= low_q[s];
      quo_q[s+1]  <= quo_nx;
      den_q[s+1]  <= den_q[s];
      ovf_q[s+1]  <= ovf_q[s];
      side_q[s+1] <= side_q[s];
    end
  end

  assign valid_o = valid_q[Q_W];
  assign quo_o   = quo_q[Q_W];
  assign ovf_o   = ovf_q[Q_W];
  assign side_o  = side_q[Q_W];

endmodule

// ----- src/tpt_back.sv -----
// ----------------------------------------------------------------------------
// tpt_back
// Clipping of the phase times and peak, then the signed total: two stages.
// ----------------------------------------------------------------------------
module tpt_back import tpt_pkg::*; #(
  parameter int unsigned WORD_WIDTH = WordWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [WORD_WIDTH-1:0] quo_a_i,
  input  logic                  ovf_a_i,
  input  logic                  neg_a_i,
  input  logic [WORD_WIDTH-1:0] quo_b_i,
  input  logic                  ovf_b_i,
  input  logic                  neg_b_i,
  input  logic [WORD_WIDTH-1:0] quo_c_i,
  input  logic                  ovf_c_i,
  input  logic                  tri_i,
  input  logic [WORD_WIDTH-1:0] root_i,
  input  logic [WORD_WIDTH-2:0] limit_i,
  output logic                  valid_o,
  output logic                  is_triangular_o,
  output logic [WORD_WIDTH-2:0] peak_speed_o,
  output logic [WORD_WIDTH-1:0] accel_time_o,
  output logic [WORD_WIDTH-1:0] decel_time_o,
  output logic [WORD_WIDTH-2:0] cruise_time_o,
  output logic [WORD_WIDTH-1:0] total_time_o,
  output logic                  saturated_o
);

  localparam int unsigned W = WORD_WIDTH;
  localparam logic [W-1:0] PosMax = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NegMag = {1'b1, {(W-1){1'b0}}};

  // stage 1
  logic [W-1:0] lim_a, lim_b, mag_a, mag_b;
  logic         clip_a, clip_b, clip_c, clip_p;
  logic [W-2:0] cruise, peak;

  logic         valid1_q, tri1_q, sat1_q, neg_a1_q, neg_b1_q;
  logic [W-1:0] mag_a1_q, mag_b1_q;
  logic [W-2:0] cruise1_q, peak1_q;

  // stage 2
  logic [W+1:0]        pos, negs;
  logic signed [W+2:0] tsum, hi_lim, lo_lim;
  logic [W-1:0]        total;
  logic                clip_t;

  logic         valid2_q, tri2_q, sat2_q;
  logic [W-2:0] peak2_q, cruise2_q;
  logic [W-1:0] accel2_q, decel2_q, total2_q;

  always_comb begin
    lim_a  = neg_a_i ? NegMag : PosMax;
    lim_b  = neg_b_i ? NegMag : PosMax;
    clip_a = ovf_a_i || (quo_a_i > lim_a);
    clip_b = ovf_b_i || (quo_b_i > lim_b);
    mag_a  = clip_a ? lim_a : quo_a_i;
    mag_b  = clip_b ? lim_b : quo_b_i;
    clip_c = ovf_c_i || quo_c_i[W-1];
    cruise = clip_c ? PosMax[W-2:0] : quo_c_i[W-2:0];
    clip_p = tri_i && root_i[W-1];
    if (!tri_i) begin
      peak = limit_i;
    end else if (clip_p) begin
      peak = PosMax[W-2:0];
    end else begin
      peak = root_i[W-2:0];
    end
  end

  always_comb begin
    pos    = (W+2)'(cruise1_q) + (neg_a1_q ? '0 : (W+2)'(mag_a1_q))
           + (neg_b1_q ? '0 : (W+2)'(mag_b1_q));
    negs   = (neg_a1_q ? (W+2)'(mag_a1_q) : '0) + (neg_b1_q ? (W+2)'(mag_b1_q) : '0);
    tsum   = $signed({1'b0, pos}) - $signed({1'b0, negs});
    hi_lim = $signed({3'b000, PosMax});
    lo_lim = -$signed({3'b000, NegMag});
    clip_t = 1'b0;
    priority if (tsum > hi_lim) begin
      total  = PosMax;
      clip_t = 1'b1;
    end else if (tsum < lo_lim) begin
      total  = NegMag;
      clip_t = 1'b1;
    end else begin
      total  = tsum[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tri1_q    <= tri_i;
    sat1_q    <= clip_a | clip_b | clip_c | clip_p;
    mag_a1_q  <= mag_a;
    mag_b1_q  <= mag_b;
    neg_a1_q  <= neg_a_i && (mag_a != '0);
    neg_b1_q  <= neg_b_i && (mag_b != '0);
    cruise1_q <= cruise;
    peak1_q   <= peak;

    tri2_q    <= tri1_q;
    sat2_q    <= sat1_q | clip_t;
    peak2_q   <= peak1_q;
    cruise2_q <= cruise1_q;
    accel2_q  <= neg_a1_q ? (W'(0) - mag_a1_q) : mag_a1_q;
    decel2_q  <= neg_b1_q ? (W'(0) - mag_b1_q) : mag_b1_q;
    total2_q  <= total;
  end

  assign valid_o         = valid2_q;
  assign is_triangular_o = tri2_q;
  assign peak_speed_o    = peak2_q;
  assign accel_time_o    = accel2_q;
  assign decel_time_o    = decel2_q;
  assign cruise_time_o   = cruise2_q;
  assign total_time_o    = total2_q;
  assign saturated_o     = sat2_q;

endmodule

// ----- src/trapezoid_profile_timing.sv -----
// ----------------------------------------------------------------------------
// trapezoid_profile_timing
// Trapezoidal velocity profile timing in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+-------------------
//  command  | distance_i start_speed_i end_speed_i          | start & !busy
//           | speed_limit_i accel_limit_i                   |
//  result   | is_triangular_o peak_speed_o accel_time_o     | valid_o, one cycle
//           | decel_time_o cruise_time_o total_time_o       |
//           | saturated_o                                   |
//
//  one transaction is taken every cycle while busy is low; each result
//  goes through the front end, root, root alignment, phase dividers and
//  back end, as deep as the cruise path with its two dividers in series
//  busy is high only while reset is held and the cycle after; it never
//  rises again, since results are not back-pressured
//  reset clears the valid bits of every stage; data registers are not reset
//
module trapezoid_profile_timing import tpt_pkg::*; #(
  parameter int unsigned WORD_WIDTH = WordWidthDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [WORD_WIDTH-1:0] distance_i,
  input  logic [WORD_WIDTH-1:0] start_speed_i,
  input  logic [WORD_WIDTH-1:0] end_speed_i,
  input  logic [WORD_WIDTH-2:0] speed_limit_i,
  input  logic [WORD_WIDTH-2:0] accel_limit_i,
  output logic                  valid_o,
  output logic                  is_triangular_o,
  output logic [WORD_WIDTH-2:0] peak_speed_o,
  output logic [WORD_WIDTH-1:0] accel_time_o,
  output logic [WORD_WIDTH-1:0] decel_time_o,
  output logic [WORD_WIDTH-2:0] cruise_time_o,
  output logic [WORD_WIDTH-1:0] total_time_o,
  output logic                  saturated_o
);

  localparam int unsigned W   = WORD_WIDTH;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned Q1  = 2 * W - F;      // cruise distance quotient width
  localparam int unsigned DLY = W - F;          // root path catch-up to the cruise divider
  localparam int unsigned SQ_SIDE = 4 * W - 1;  // tri, v0, vt, vm, am
  localparam int unsigned DW  = SQ_SIDE + W;

  logic busy_q;
  logic accept;

  // front end
  logic          fe_valid, fe_tri;
  logic [2*W:0]  fe_sum, fe_excess;
  logic [W-1:0]  fe_v0, fe_vt;
  logic [W-2:0]  fe_vm, fe_am;

  // root path
  logic               sq_valid;
  logic [W-1:0]       sq_root;
  logic [SQ_SIDE-1:0] sq_side;
  logic [DW-1:0]      dly_q   [DLY];
  logic               dly_v_q [DLY];
  logic [DW-1:0]      dly_out;
  logic               dly_valid;

  logic         al_tri;
  logic [W-1:0] al_root, al_v0, al_vt, al_top;
  logic [W-2:0] al_vm, al_am;

  // cruise path
  logic          c1_valid, c1_ovf;
  logic [Q1-1:0] c1_quo, c1_lc;
  logic [W-2:0]  c1_vm, c1_den;

  // phase numerators
  logic [W-1:0] diff_a, diff_b;
  logic         neg_a, neg_b;

  // divider outputs
  logic         pa_valid, pa_ovf, pa_neg;
  logic [W-1:0] pa_quo;
  logic         pb_valid, pb_ovf, pb_neg;
  logic [W-1:0] pb_quo;
  logic         c2_valid, c2_ovf;
  logic [W-1:0] c2_quo;
  logic [2*W-1:0] c2_side;

  // a command transaction is taken whenever the pipe is out of reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy   = busy_q;
  assign accept = start & ~busy_q;

  tpt_front #(
    .WORD_WIDTH (W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (accept),
    .distance_i    (distance_i),
    .start_speed_i (start_speed_i),
    .end_speed_i   (end_speed_i),
    .speed_limit_i (speed_limit_i),
    .accel_limit_i (accel_limit_i),
    .valid_o       (fe_valid),
    .sum_o         (fe_sum),
    .excess_o      (fe_excess),
    .tri_o         (fe_tri),
    .start_mag_o   (fe_v0),
    .end_mag_o     (fe_vt),
    .limit_o       (fe_vm),
    .accel_o       (fe_am)
  );

  // triangular peak: floor(sqrt(S/2))
  tpt_sqrt #(
    .WORD_WIDTH (W),
    .SIDE_W     (SQ_SIDE)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fe_valid),
    .rad_i   (fe_sum[2*W:1]),
    .side_i  ({fe_tri, fe_v0, fe_vt, fe_vm, fe_am}),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // cruise distance (S - 2 vmax^2) / 2a, zero numerator when triangular
  tpt_div #(
    .NUM_W  (2 * W + 1),
    .DEN_W  (W),
    .Q_W    (Q1),
    .SIDE_W (W - 1)
  ) u_div_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fe_valid),
    .num_i   (fe_excess),
    .den_i   ({fe_am, 1'b0}),
    .side_i  (fe_vm),
    .valid_o (c1_valid),
    .quo_o   (c1_quo),
    .ovf_o   (c1_ovf),
    .side_o  (c1_vm)
  );

  // root result waits for the longer cruise distance divider
  for (genvar k = 0; k < DLY; k++) begin : g_dly
    if (k == 0) begin : g_head
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          dly_v_q[k] <= 1'b0;
        end else begin
          dly_v_q[k] <= sq_valid;
        end
      end
      always_ff @(posedge clk_i) begin
        dly_q[k] <= {sq_root, sq_side};
      end
    end else begin : g_tail
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          dly_v_q[k] <= 1'b0;
        end else begin
          dly_v_q[k] <= dly_v_q[k-1];
        end
      end
      always_ff @(posedge clk_i) begin
        dly_q[k] <= dly_q[k-1];
      end
    end
  end

  assign dly_out   = dly_q[DLY-1];
  assign dly_valid = dly_v_q[DLY-1];
  assign {al_root, al_tri, al_v0, al_vt, al_vm, al_am} = dly_out;

  // peak used for the phase times: unclipped root, or the limit
  assign al_top = al_tri ? al_root : {1'b0, al_vm};
  assign neg_a  = al_top < al_v0;
  assign neg_b  = al_top < al_vt;
  assign diff_a = neg_a ? (al_v0 - al_top) : (al_top - al_v0);
  assign diff_b = neg_b ? (al_vt - al_top) : (al_top - al_vt);

  // an overflowing cruise distance only has to stay above the clip point
  assign c1_lc  = c1_ovf ? '1 : c1_quo;
  assign c1_den = (c1_vm == '0) ? (W-1)'(1) : c1_vm;

  tpt_div #(
    .NUM_W  (W + F),
    .DEN_W  (W - 1),
    .Q_W    (W),
    .SIDE_W (1)
  ) u_div_accel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dly_valid),
    .num_i   ({diff_a, {F{1'b0}}}),
    .den_i   (al_am),
    .side_i  (neg_a),
    .valid_o (pa_valid),
    .quo_o   (pa_quo),
    .ovf_o   (pa_ovf),
    .side_o  (pa_neg)
  );

  tpt_div #(
    .NUM_W  (W + F),
    .DEN_W  (W - 1),
    .Q_W    (W),
    .SIDE_W (1)
  ) u_div_decel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dly_valid),
    .num_i   ({diff_b, {F{1'b0}}}),
    .den_i   (al_am),
    .side_i  (neg_b),
    .valid_o (pb_valid),
    .quo_o   (pb_quo),
    .ovf_o   (pb_ovf),
    .side_o  (pb_neg)
  );

  // cruise time: cruise distance over vmax; carries the peak information
  tpt_div #(
    .NUM_W  (2 * W),
    .DEN_W  (W - 1),
    .Q_W    (W),
    .SIDE_W (2 * W)
  ) u_div_cruise (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c1_valid),
    .num_i   ({c1_lc, {F{1'b0}}}),
    .den_i   (c1_den),
    .side_i  ({al_tri, al_root, al_vm}),
    .valid_o (c2_valid),
    .quo_o   (c2_quo),
    .ovf_o   (c2_ovf),
    .side_o  (c2_side)
  );

  // all three dividers run in lockstep; one valid bit is enough downstream
  tpt_back #(
    .WORD_WIDTH (W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (c2_valid & pa_valid & pb_valid),
    .quo_a_i         (pa_quo),
    .ovf_a_i         (pa_ovf),
    .neg_a_i         (pa_neg),
    .quo_b_i         (pb_quo),
    .ovf_b_i         (pb_ovf),
    .neg_b_i         (pb_neg),
    .quo_c_i         (c2_quo),
    .ovf_c_i         (c2_ovf),
    .tri_i           (c2_side[2*W-1]),
    .root_i          (c2_side[2*W-2:W-1]),
    .limit_i         (c2_side[W-2:0]),
    .valid_o         (valid_o),
    .is_triangular_o (is_triangular_o),
    .peak_speed_o    (peak_speed_o),
    .accel_time_o    (accel_time_o),
    .decel_time_o    (decel_time_o),
    .cruise_time_o   (cruise_time_o),
    .total_time_o    (total_time_o),
    .saturated_o     (saturated_o)
  );

endmodule

// ----- src/tpt_checker.sv -----
// ----------------------------------------------------------------------------
// tpt_checker
// Port-level checks for trapezoid_profile_timing, bound to the top level.
// ----------------------------------------------------------------------------
module tpt_checker import tpt_pkg::*; #(
  parameter int unsigned WORD_WIDTH = WordWidthDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic                  valid_o,
  input logic                  is_triangular_o,
  input logic [WORD_WIDTH-1:0] accel_time_o,
  input logic [WORD_WIDTH-1:0] decel_time_o,
  input logic [WORD_WIDTH-2:0] cruise_time_o,
  input logic [WORD_WIDTH-1:0] total_time_o,
  input logic                  saturated_o
);

  localparam int unsigned Lat = tpt_latency(WORD_WIDTH, FRAC_BITS);

  // once out of reset the block keeps taking transactions
  a_busy_stays_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !busy)
    else $error("busy rose after reset");

  // every result strobe traces back to a command taken at the fixed latency
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, Lat))
    else $error("result strobe without a matching command");

  // triangular profiles have no cruise phase
  a_tri_no_cruise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && is_triangular_o |-> cruise_time_o == '0)
    else $error("cruise time on a triangular profile");

  // with no clipping and no negative phase the total covers the accel phase
  a_total_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !saturated_o && !accel_time_o[WORD_WIDTH-1] && !decel_time_o[WORD_WIDTH-1]
      |-> $signed(total_time_o) >= $signed(accel_time_o))
    else $error("total time below accel time");

endmodule

bind trapezoid_profile_timing tpt_checker #(
  .WORD_WIDTH (WORD_WIDTH),
  .FRAC_BITS  (FRAC_BITS)
) u_tpt_checker (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives move commands into the trapezoid profile timing block with random
// gaps, predicts each result in wide integer arithmetic unless a directed row
// gives it, and checks every strobed result against the oldest expectation.
// ----------------------------------------------------------------------------
module testbench;
  import tpt_pkg::*;

  localparam int unsigned W = WordWidthDef;
  localparam int unsigned F = FracBitsDef;
  localparam int unsigned LATENCY = tpt_latency(W, F);
  localparam int unsigned IDLE_LIMIT = 20 * LATENCY + 2000;
  localparam int unsigned N_RANDOM = 1600;
  localparam logic [127:0] POS_MAX = (128'd1 << (W - 1)) - 1;
  localparam logic [127:0] NEG_MAG = 128'd1 << (W - 1);

  typedef struct packed {
    logic [W-1:0] len;
    logic [W-1:0] v0;
    logic [W-1:0] vt;
    logic [W-2:0] vmax;
    logic [W-2:0] amax;
  } move_t;

  typedef struct packed {
    logic         tri_o;
    logic [W-2:0] peak;
    logic [W-1:0] t_acc;
    logic [W-1:0] t_dec;
    logic [W-2:0] t_cru;
    logic [W-1:0] t_tot;
    logic         sat;
  } timing_t;

  typedef struct packed {
    move_t   mv;
    logic    typed;
    timing_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [W-1:0] distance_i = '0;
  logic [W-1:0] start_speed_i = '0;
  logic [W-1:0] end_speed_i = '0;
  logic [W-2:0] speed_limit_i = '0;
  logic [W-2:0] accel_limit_i = '0;
  logic valid_o;
  logic is_triangular_o;
  logic [W-2:0] peak_speed_o;
  logic [W-1:0] accel_time_o;
  logic [W-1:0] decel_time_o;
  logic [W-2:0] cruise_time_o;
  logic [W-1:0] total_time_o;
  logic saturated_o;

  timing_t pending_timings[$];
  int unsigned n_errors = 0;
  int unsigned idle_cycles = 0;
  logic took_cmd;

  always #10 clk_i = ~clk_i;

  trapezoid_profile_timing DUT (.*);

  // magnitude of a two's complement word, most negative value taken exactly
  function automatic logic [127:0] mag_of(logic [W-1:0] x);
    logic [127:0] m;
    m = x[W-1] ? (128'd1 << W) - x : x;
    return m;
  endfunction

  // floor(num * 2^F / den) clipped to lim
  function automatic logic [127:0] scaled_quot(logic [127:0] num, logic [127:0] den,
                                               logic [127:0] lim, ref logic clip);
    logic [127:0] q;
    q = (num << F) / den;
    if (q > lim) begin
      clip = 1'b1;
      q = lim;
    end
    return q;
  endfunction

  // signed phase duration (top - sub) / accel, kept as sign and magnitude
  function automatic void phase_dur(logic [127:0] top, logic [127:0] sub, logic [127:0] acc,
                                    ref logic clip, output logic neg,
                                    output logic [127:0] mag);
    if (top >= sub) begin
      neg = 1'b0;
      mag = scaled_quot(top - sub, acc, POS_MAX, clip);
    end else begin
      neg = 1'b1;
      mag = scaled_quot(sub - top, acc, NEG_MAG, clip);
    end
    if (mag == 0) neg = 1'b0;
  endfunction

  function automatic logic [W-1:0] to_word(logic neg, logic [127:0] mag);
    logic [127:0] v;
    v = neg ? -mag : mag;
    return v[W-1:0];
  endfunction

  function automatic timing_t profile_timing(move_t mv);
    logic [127:0] d, a, b, vm, am, s, lim2, x, r, t, peak, cru, pos, negs;
    logic [127:0] ma, md, mt;
    logic na, nd, nt, clip, tri_p;
    timing_t res;
    d = mag_of(mv.len);
    a = mag_of(mv.v0);
    b = mag_of(mv.vt);
    vm = mv.vmax;
    am = (mv.amax == 0) ? 128'd1 : mv.amax;
    clip = 1'b0;
    cru = 0;
    s = a * a + b * b + 2 * am * d;
    lim2 = 2 * vm * vm;
    tri_p = lim2 >= s;
    if (tri_p) begin
      // floored root of half of s, the squared speeds plus 2*a*d
      x = s >> 1;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
        t = r | (128'd1 << i);
        if (t * t <= x) r = t;
      end
      peak = r;
      if (peak > POS_MAX) begin
        peak = POS_MAX;
        clip = 1'b1;
      end
      phase_dur(r, a, am, clip, na, ma);
      phase_dur(r, b, am, clip, nd, md);
    end else begin
      peak = vm;
      phase_dur(vm, a, am, clip, na, ma);
      phase_dur(vm, b, am, clip, nd, md);
      // cruise distance truncated before the division by the speed
      cru = scaled_quot((s - lim2) / (am << 1), (vm == 0) ? 128'd1 : vm, POS_MAX, clip);
    end
    pos = cru + (na ? 128'd0 : ma) + (nd ? 128'd0 : md);
    negs = (na ? ma : 128'd0) + (nd ? md : 128'd0);
    if (pos >= negs) begin
      nt = 1'b0;
      mt = pos - negs;
      if (mt > POS_MAX) begin
        mt = POS_MAX;
        clip = 1'b1;
      end
    end else begin
      nt = 1'b1;
      mt = negs - pos;
      if (mt > NEG_MAG) begin
        mt = NEG_MAG;
        clip = 1'b1;
      end
    end
    res.tri_o = tri_p;
    res.peak = peak[W-2:0];
    res.t_acc = to_word(na, ma);
    res.t_dec = to_word(nd, md);
    res.t_cru = cru[W-2:0];
    res.t_tot = to_word(nt, mt);
    res.sat = clip;
    return res;
  endfunction

  // wide random value, most of them small so both profile shapes turn up
  function automatic logic [W-1:0] rand_word();
    logic [W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = {1'b1, {(W - 1){1'b0}}};
      2: v = {1'b0, {(W - 1){1'b1}}};
      3, 4, 5: v = v >> $urandom_range(8, 20);
      6, 7: v = v >> $urandom_range(0, 31);
      default: ;
    endcase
    if ($urandom_range(0, 1) && (v != 0)) v = -v;
    return v;
  endfunction

  function automatic logic [W-2:0] rand_limit();
    logic [W-1:0] v;
    v = rand_word();
    if (v[W-1]) v = -v;
    if ($urandom_range(0, 19) == 0) v = '0;
    return v[W-2:0];
  endfunction

  // mostly no gap, some short gaps and a few long ones
  task automatic idle_gap();
    int unsigned n;
    case ($urandom_range(0, 19))
      0: n = $urandom_range(20, 120);
      1, 2, 3, 4, 5: n = $urandom_range(1, 4);
      default: n = 0;
    endcase
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // one command transaction; waits until the block takes it
  task automatic issue_move(move_t mv, logic typed, timing_t res);
    @(negedge clk_i);
    start <= 1'b1;
    distance_i <= mv.len;
    start_speed_i <= mv.v0;
    end_speed_i <= mv.vt;
    speed_limit_i <= mv.vmax;
    accel_limit_i <= mv.amax;
    do @(posedge clk_i); while (busy);
    pending_timings.push_back(typed ? res : profile_timing(mv));
  endtask

  // result side: the receiver cannot stall, so every strobe is a transaction
  always @(posedge clk_i) begin
    timing_t want;
    if (rst_ni && valid_o) begin
      if (pending_timings.size() == 0) begin
        $error("result with nothing expected");
        n_errors++;
      end else begin
        want = pending_timings.pop_front();
        if (is_triangular_o !== want.tri_o) begin
          $error("is_triangular: expected %0d, actual %0d", want.tri_o, is_triangular_o);
          n_errors++;
        end
        if (peak_speed_o !== want.peak) begin
          $error("peak_speed: expected %h, actual %h", want.peak, peak_speed_o);
          n_errors++;
        end
        if (accel_time_o !== want.t_acc) begin
          $error("accel_time: expected %h, actual %h", want.t_acc, accel_time_o);
          n_errors++;
        end
        if (decel_time_o !== want.t_dec) begin
          $error("decel_time: expected %h, actual %h", want.t_dec, decel_time_o);
          n_errors++;
        end
        if (cruise_time_o !== want.t_cru) begin
          $error("cruise_time: expected %h, actual %h", want.t_cru, cruise_time_o);
          n_errors++;
        end
        if (total_time_o !== want.t_tot) begin
          $error("total_time: expected %h, actual %h", want.t_tot, total_time_o);
          n_errors++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %0d, actual %0d", want.sat, saturated_o);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles where neither side moves a transaction
  always @(posedge clk_i) begin
    took_cmd = start && !busy;
    if (took_cmd || valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    row_t directed[];
    move_t mv;
    timing_t none;
    int unsigned waited;
    none = '0;
    directed = '{
      // all zero: triangular with nothing to do
      '{'{32'h0, 32'h0, 32'h0, 31'h1, 31'h1}, 1'b1,
        '{1'b1, 31'h0, 32'h0, 32'h0, 31'h0, 32'h0, 1'b0}},
      // zero acceleration limit taken as one lsb
      '{'{32'h0, 32'h0, 32'h0, 31'h1, 31'h0}, 1'b1,
        '{1'b1, 31'h0, 32'h0, 32'h0, 31'h0, 32'h0, 1'b0}},
      // most negative start speed against a tiny limit: times clip
      '{'{32'h0, 32'h8000_0000, 32'h0, 31'h1, 31'h1}, 1'b1,
        '{1'b0, 31'h1, 32'h8000_0000, 32'h0001_0000, 31'h7fff_ffff, 32'h0000_ffff,
          1'b1}},
      '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff, 31'h7fff_ffff},
        1'b0, none},
      '{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff},
        1'b0, none},
      '{'{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 31'h1, 31'h1}, 1'b0, none},
      '{'{32'h7fff_ffff, 32'h0, 32'h0, 31'h7fff_ffff, 31'h1}, 1'b0, none},
      '{'{32'h7fff_ffff, 32'h0, 32'h0, 31'h0, 31'h0}, 1'b0, none},
      // zero speed limit with some motion
      '{'{32'h0001_0000, 32'h0, 32'h0, 31'h0, 31'h0001_0000}, 1'b0, none},
      // triangular move from rest to rest
      '{'{32'h0004_0000, 32'h0, 32'h0, 31'h0010_0000, 31'h0001_0000}, 1'b0, none},
      // trapezoid with a cruise phase
      '{'{32'h0064_0000, 32'h0001_0000, 32'hfffe_0000, 31'h0004_0000, 31'h0002_0000},
        1'b0, none},
      // start speed above peak gives a negative accel time
      '{'{32'h0000_0001, 32'h0050_0000, 32'h0, 31'h0060_0000, 31'h0001_0000}, 1'b0, none},
      '{'{32'hffff_0000, 32'h0, 32'h0080_0000, 31'h0070_0000, 31'h0000_0001}, 1'b0, none},
      '{'{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 31'h2aaa_aaaa, 31'h5555_5555},
        1'b0, none},
      '{'{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 31'h5555_5555, 31'h2aaa_aaaa},
        1'b0, none}
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      issue_move(directed[i].mv, directed[i].typed, directed[i].res);
      idle_gap();
    end

    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      mv.len = rand_word();
      mv.v0 = rand_word();
      mv.vt = rand_word();
      mv.vmax = rand_limit();
      mv.amax = rand_limit();
      issue_move(mv, 1'b0, none);
      idle_gap();
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_timings.size() != 0) @(posedge clk_i);
    // drain: a stray strobe would show up within one pipeline depth
    waited = 0;
    while (waited < LATENCY + 10) begin
      @(posedge clk_i);
      waited++;
    end

    if (n_errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- trapezoid_profile_timing.f -----
src/tpt_pkg.sv
src/tpt_front.sv
src/tpt_sqrt.sv
src/tpt_div.sv
src/tpt_back.sv
src/trapezoid_profile_timing.sv
src/tpt_checker.sv
test/testbench.sv
